// ===== src/pvfp_pkg.sv =====
// Package for the periodic velocity block, imported by all modules: widths,
// register indexes and the configuration bundle. No dependencies.
package pvfp_pkg;

  localparam int AXES    = 3;
  localparam int POS_W   = 32;
  localparam int DISP_W  = 33;
  localparam int BOX_W   = 31;
  localparam int TS_W    = 23;
  localparam int MASK_W  = 3;
  localparam int CIDX_W  = 3;
  localparam int CDATA_W = 31;

  typedef enum logic [CIDX_W-1:0] {
    CFG_BOX_WIDTH  = 3'd0,
    CFG_BOX_HEIGHT = 3'd1,
    CFG_BOX_DEPTH  = 3'd2,
    CFG_CYCLIC     = 3'd3,
    CFG_TIME_STEP  = 3'd4
  } cfg_idx_e;

  typedef logic signed [DISP_W-1:0] disp_t;

  // Configuration as seen by the datapath; time_step already has zero mapped to one.
  typedef struct packed {
    logic [AXES-1:0][BOX_W-1:0] box;
    logic [MASK_W-1:0]          cyclic;
    logic [TS_W-1:0]            time_step;
  } cfg_t;

endpackage

// ===== src/pvfp_if.sv =====
// Valid/ready channel interfaces for particle positions and velocities.
// Depends on nothing; widths are fixed by the data format.
interface pvfp_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] prev_x;
  logic signed [31:0] prev_y;
  logic signed [31:0] prev_z;
  logic signed [31:0] cur_x;
  logic signed [31:0] cur_y;
  logic signed [31:0] cur_z;
  modport source (output valid, prev_x, prev_y, prev_z, cur_x, cur_y, cur_z,
                  input ready);
  modport sink (input valid, prev_x, prev_y, prev_z, cur_x, cur_y, cur_z,
                output ready);
endinterface

interface pvfp_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] vel_x;
  logic signed [31:0] vel_y;
  logic signed [31:0] vel_z;
  logic               saturated;
  modport source (output valid, vel_x, vel_y, vel_z, saturated, input ready);
  modport sink (input valid, vel_x, vel_y, vel_z, saturated, output ready);
endinterface

// ===== src/periodic_velocity_from_positions_top.sv =====
// Top level of the periodic velocity block: configuration registers, the
// displacement stage and the wrap and divide pipelines. Depends on pvfp_pkg,
// pvfp_if, pvfp_wrap and pvfp_div.
//
// One particle is taken per clock unless the pipeline is full behind a blocked
// output; each velocity passes through 70 register stages: one displacement
// stage, 35 wrap stages and 34 divide stages. The depth comes from the restoring
// remainder, which resolves one bit of |d + L/2| per stage, and the restoring
// divider, which resolves one quotient bit per stage. Every stage holds its beat
// when the stage after it is full and blocked, so empty stages keep filling
// while the output waits. Configuration is meant to change only while the
// pipeline is empty.
module periodic_velocity_from_positions_top #(
  parameter int FRAC_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [pvfp_pkg::CIDX_W-1:0]   cfg_idx_i,
  input  logic [pvfp_pkg::CDATA_W-1:0]  cfg_data_i,
  pvfp_in_if.sink                       in_if,
  pvfp_out_if.source                    out_if
);
  import pvfp_pkg::*;

  logic [AXES-1:0][BOX_W-1:0] box_q;
  logic [MASK_W-1:0]          cyclic_q;
  logic [TS_W-1:0]            ts_q;
  cfg_t                       cfg;

  logic   d_valid_q;
  disp_t  d_q [AXES];
  logic   wrap_ready;
  logic   wrap_valid;
  disp_t  wrap_disp [AXES];
  logic   div_ready;
  logic signed [31:0] vel [AXES];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      box_q    <= {AXES{BOX_W'(65536)}};
      cyclic_q <= MASK_W'(7);
      ts_q     <= TS_W'(6554);
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_BOX_WIDTH:  box_q[0] <= cfg_data_i[BOX_W-1:0];
        CFG_BOX_HEIGHT: box_q[1] <= cfg_data_i[BOX_W-1:0];
        CFG_BOX_DEPTH:  box_q[2] <= cfg_data_i[BOX_W-1:0];
        CFG_CYCLIC:     cyclic_q <= cfg_data_i[MASK_W-1:0];
        CFG_TIME_STEP:  ts_q     <= cfg_data_i[TS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg.box       = box_q;
    cfg.cyclic    = cyclic_q;
    // A zero time step counts as the smallest step.
    cfg.time_step = (ts_q == '0) ? TS_W'(1) : ts_q;
  end

  assign in_if.ready = !d_valid_q || wrap_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d_valid_q <= 1'b0;
    end else if (in_if.ready) begin
      d_valid_q <= in_if.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_if.ready) begin
      d_q[0] <= $signed({in_if.cur_x[POS_W-1], in_if.cur_x}) -
                $signed({in_if.prev_x[POS_W-1], in_if.prev_x});
      d_q[1] <= $signed({in_if.cur_y[POS_W-1], in_if.cur_y}) -
                $signed({in_if.prev_y[POS_W-1], in_if.prev_y});
      d_q[2] <= $signed({in_if.cur_z[POS_W-1], in_if.cur_z}) -
                $signed({in_if.prev_z[POS_W-1], in_if.prev_z});
    end
  end

  pvfp_wrap u_wrap (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (d_valid_q),
    .in_ready_o  (wrap_ready),
    .in_disp_i   (d_q),
    .out_valid_o (wrap_valid),
    .out_ready_i (div_ready),
    .out_disp_o  (wrap_disp)
  );

  pvfp_div #(
    .FRAC_BITS (FRAC_BITS)
  ) u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ts_i        (cfg.time_step),
    .in_valid_i  (wrap_valid),
    .in_ready_o  (div_ready),
    .in_disp_i   (wrap_disp),
    .out_valid_o (out_if.valid),
    .out_ready_i (out_if.ready),
    .out_vel_o   (vel),
    .out_sat_o   (out_if.saturated)
  );

  assign out_if.vel_x = vel[0];
  assign out_if.vel_y = vel[1];
  assign out_if.vel_z = vel[2];

  // Input back-pressure only arises when every stage is full behind a blocked output.
  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_if.ready |-> (out_if.valid && !out_if.ready))
    else $error("input stalled while the pipeline had room");

  a_sat_means_clamped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_if.valid && out_if.saturated) |->
      (out_if.vel_x == 32'sh7FFF_FFFF || out_if.vel_x == 32'sh8000_0000 ||
       out_if.vel_y == 32'sh7FFF_FFFF || out_if.vel_y == 32'sh8000_0000 ||
       out_if.vel_z == 32'sh7FFF_FFFF || out_if.vel_z == 32'sh8000_0000))
    else $error("saturation flag without a clamped component");

  a_zero_step_is_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cfg_we_i && cfg_idx_i == CFG_TIME_STEP && cfg_data_i[TS_W-1:0] == '0)
      |=> (cfg.time_step == TS_W'(1)))
    else $error("zero time step not mapped to one");

endmodule

// ===== src/pvfp_wrap.sv =====
// Minimum-image wrap of three displacements, one remainder bit per stage.
// Depends on pvfp_pkg.
module pvfp_wrap (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  pvfp_pkg::cfg_t      cfg_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  pvfp_pkg::disp_t     in_disp_i [pvfp_pkg::AXES],
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output pvfp_pkg::disp_t     out_disp_o [pvfp_pkg::AXES]
);
  import pvfp_pkg::*;

  localparam int UW = DISP_W;      // magnitude of d + h fits here
  localparam int NS = UW + 2;      // entry, one stage per bit, output

  logic [NS-1:0]  valid_q;
  logic [NS-1:0]  rdy;
  disp_t          d_q    [NS-1][AXES];
  logic           need_q [NS-1][AXES];
  logic           xneg_q [NS-1][AXES];
  logic [UW-1:0]  u_q    [NS-1][AXES];
  logic [BOX_W-1:0] rem_q [NS-1][AXES];
  disp_t          out_q  [AXES];

  disp_t          e_d    [AXES];
  logic           e_need [AXES];
  logic           e_xneg [AXES];
  logic [UW-1:0]  e_u    [AXES];

  always_comb begin
    rdy[NS-1] = !valid_q[NS-1] || out_ready_i;
    for (int k = NS - 2; k >= 0; k--) begin
      rdy[k] = !valid_q[k] || rdy[k+1];
    end
  end

  assign in_ready_o  = rdy[0];
  assign out_valid_o = valid_q[NS-1];
  assign out_disp_o  = out_q;

  // Entry: decide whether the axis wraps and form |d + h| for the remainder.
  always_comb begin
    logic [DISP_W-1:0]  mag;
    logic [BOX_W-2:0]   half;
    logic signed [DISP_W:0] x;
    logic [DISP_W:0]    xa;
    for (int a = 0; a < AXES; a++) begin
      e_d[a]  = in_disp_i[a];
      mag     = in_disp_i[a][DISP_W-1] ? DISP_W'(-in_disp_i[a]) : DISP_W'(in_disp_i[a]);
      half    = cfg_i.box[a][BOX_W-1:1];
      e_need[a] = cfg_i.cyclic[a] && (cfg_i.box[a] != '0) &&
                  ({mag, 1'b0} > {3'b000, cfg_i.box[a]});
      x = $signed({in_disp_i[a][DISP_W-1], in_disp_i[a]}) + $signed({4'b0000, half});
      e_xneg[a] = x[DISP_W];
      xa      = x[DISP_W] ? (DISP_W+1)'(-x) : (DISP_W+1)'(x);
      e_u[a]  = xa[UW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (rdy[0]) valid_q[0] <= in_valid_i;
      for (int k = 1; k < NS; k++) begin
        if (rdy[k]) valid_q[k] <= valid_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    logic [BOX_W:0]   tr;
    logic [BOX_W-1:0] r;
    logic [BOX_W-2:0] half;
    if (rdy[0]) begin
      for (int a = 0; a < AXES; a++) begin
        d_q[0][a]    <= e_d[a];
        need_q[0][a] <= e_need[a];
        xneg_q[0][a] <= e_xneg[a];
        u_q[0][a]    <= e_u[a];
        rem_q[0][a]  <= '0;
      end
    end
    // Restoring remainder: stage k brings down the next bit of |d + h|.
    for (int k = 1; k < NS - 1; k++) begin
      if (rdy[k]) begin
        for (int a = 0; a < AXES; a++) begin
          tr = {rem_q[k-1][a], u_q[k-1][a][UW-1]};
          if (tr >= {1'b0, cfg_i.box[a]}) tr = tr - {1'b0, cfg_i.box[a]};
          d_q[k][a]    <= d_q[k-1][a];
          need_q[k][a] <= need_q[k-1][a];
          xneg_q[k][a] <= xneg_q[k-1][a];
          u_q[k][a]    <= {u_q[k-1][a][UW-2:0], 1'b0};
          rem_q[k][a]  <= tr[BOX_W-1:0];
        end
      end
    end
    if (rdy[NS-1]) begin
      for (int a = 0; a < AXES; a++) begin
        // A negative dividend turns the remainder into its floor form.
        r = rem_q[NS-2][a];
        if (xneg_q[NS-2][a] && (r != '0)) r = cfg_i.box[a] - r;
        half = cfg_i.box[a][BOX_W-1:1];
        out_q[a] <= need_q[NS-2][a] ?
                    ($signed({2'b00, r}) - $signed({3'b000, half})) : d_q[NS-2][a];
      end
    end
  end

endmodule

// ===== src/pvfp_div.sv =====
// Pipelined restoring divider: displacement times 2^FRAC_BITS over time step,
// with saturation to 32 bits. Depends on pvfp_pkg.
module pvfp_div #(
  parameter int FRAC_BITS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [pvfp_pkg::TS_W-1:0] ts_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  pvfp_pkg::disp_t     in_disp_i [pvfp_pkg::AXES],
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic signed [31:0]  out_vel_o [pvfp_pkg::AXES],
  output logic                out_sat_o
);
  import pvfp_pkg::*;

  localparam int QW = 32;
  localparam int NW = DISP_W + FRAC_BITS;
  localparam int NS = QW + 2;

  logic [NS-1:0]    valid_q;
  logic [NS-1:0]    rdy;
  logic             neg_q [NS-1][AXES];
  logic             ovf_q [NS-1][AXES];
  logic [QW-1:0]    lo_q  [NS-1][AXES];
  logic [QW-1:0]    q_q   [NS-1][AXES];
  logic [TS_W-1:0]  rem_q [NS-1][AXES];
  logic signed [31:0] vel_q [AXES];
  logic             sat_q;

  logic             e_neg [AXES];
  logic             e_ovf [AXES];
  logic [QW-1:0]    e_lo  [AXES];
  logic [TS_W-1:0]  e_rem [AXES];

  always_comb begin
    rdy[NS-1] = !valid_q[NS-1] || out_ready_i;
    for (int k = NS - 2; k >= 0; k--) begin
      rdy[k] = !valid_q[k] || rdy[k+1];
    end
  end

  assign in_ready_o  = rdy[0];
  assign out_valid_o = valid_q[NS-1];
  assign out_vel_o   = vel_q;
  assign out_sat_o   = sat_q;

  // Entry: the upper numerator bits decide overflow and seed the remainder.
  always_comb begin
    logic [DISP_W-1:0] mag;
    logic [NW-1:0]     n;
    logic [31:0]       hi;
    for (int a = 0; a < AXES; a++) begin
      mag = in_disp_i[a][DISP_W-1] ? DISP_W'(-in_disp_i[a]) : DISP_W'(in_disp_i[a]);
      n   = {mag, {FRAC_BITS{1'b0}}};
      hi  = 32'(n[NW-1:QW]);
      e_neg[a] = in_disp_i[a][DISP_W-1];
      e_ovf[a] = hi >= 32'(ts_i);
      e_lo[a]  = n[QW-1:0];
      e_rem[a] = e_ovf[a] ? '0 : hi[TS_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (rdy[0]) valid_q[0] <= in_valid_i;
      for (int k = 1; k < NS; k++) begin
        if (rdy[k]) valid_q[k] <= valid_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    logic [TS_W:0]    tr;
    logic             ge;
    logic [QW-1:0]    q;
    logic             s;
    if (rdy[0]) begin
      for (int a = 0; a < AXES; a++) begin
        neg_q[0][a] <= e_neg[a];
        ovf_q[0][a] <= e_ovf[a];
        lo_q[0][a]  <= e_lo[a];
        q_q[0][a]   <= '0;
        rem_q[0][a] <= e_rem[a];
      end
    end
    for (int k = 1; k < NS - 1; k++) begin
      if (rdy[k]) begin
        for (int a = 0; a < AXES; a++) begin
          tr = {rem_q[k-1][a], lo_q[k-1][a][QW-1]};
          ge = tr >= {1'b0, ts_i};
          if (ge) tr = tr - {1'b0, ts_i};
          neg_q[k][a] <= neg_q[k-1][a];
          ovf_q[k][a] <= ovf_q[k-1][a];
          lo_q[k][a]  <= {lo_q[k-1][a][QW-2:0], 1'b0};
          q_q[k][a]   <= {q_q[k-1][a][QW-2:0], ge};
          rem_q[k][a] <= tr[TS_W-1:0];
        end
      end
    end
    if (rdy[NS-1]) begin
      s = 1'b0;
      for (int a = 0; a < AXES; a++) begin
        q = q_q[NS-2][a];
        if (!neg_q[NS-2][a]) begin
          if (ovf_q[NS-2][a] || q[QW-1]) begin
            vel_q[a] <= 32'sh7FFF_FFFF;
            s = 1'b1;
          end else begin
            vel_q[a] <= $signed(q);
          end
        end else begin
          if (ovf_q[NS-2][a] || (q > 32'h8000_0000)) begin
            vel_q[a] <= 32'sh8000_0000;
            s = 1'b1;
          end else begin
            vel_q[a] <= $signed(-q);
          end
        end
      end
      sat_q <= s;
    end
  end

endmodule
